/* hdl/fthc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the frequency table core.
// No dependencies; imported by the request interface, the top level and the testbench.
package fthc_pkg;

    localparam int REQ_BITS = 2;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

endpackage

/* hdl/fthc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and query responses.
// Depends on fthc_pkg for the request code width.
interface fthc_req_if
    import fthc_pkg::*;
#(
    parameter int KEY_BITS   = 10,
    parameter int COUNT_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [REQ_BITS-1:0]   req_type;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] asked_freq;

    modport source (output valid, output req_type, output key, output asked_freq,
                    input ready);
    modport sink   (input valid, input req_type, input key, input asked_freq,
                    output ready);
endinterface

interface fthc_rsp_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

/* hdl/fthc_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fthc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold the last read word while no read is issued
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/frequency_table_with_count_histogram_core.sv */
`timescale 1ns / 1ps
// Insert/delete: steps read count, read/decrement old bin, increment new bin; the
//   next request is taken during the last step. A saturated insert or a delete at zero
//   ends after the count read. The histogram memory's single read port sets these steps.
// Query: the bin is read, then the result is registered once the output slot is free;
//   the input is held until the result is registered, longer while a response waits.
// Reset: synchronous; a clearing pass over every address zeroes both memories,
//   no request is taken until it ends.
// Depends on fthc_pkg, fthc_if and fthc_ram.
module frequency_table_with_count_histogram_core
    import fthc_pkg::*;
#(
    parameter int KEY_BITS   = 10,
    parameter int COUNT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fthc_req_if.sink    i_req,
    fthc_rsp_if.source  o_rsp
);

    localparam int KEY_DEPTH = 1 << KEY_BITS;
    localparam int CNT_DEPTH = 1 << COUNT_BITS;
    localparam int HIST_BITS = KEY_BITS + 1;
    localparam int CLR_BITS  = (KEY_BITS > COUNT_BITS) ? KEY_BITS : COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT,
        ST_DEC,
        ST_INC,
        ST_QRD,
        ST_QOUT
    } t_state;

    t_state                r_state;
    logic                  r_clr_busy;
    logic [CLR_BITS-1:0]   r_clr_addr;
    logic [REQ_BITS-1:0]   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [COUNT_BITS-1:0] r_want;
    logic [COUNT_BITS-1:0] r_old;
    logic [COUNT_BITS-1:0] r_new;
    logic                  r_dec_en;
    logic                  r_inc_en;
    logic                  r_out_valid;
    logic                  r_found;

    logic                  accept;
    logic                  out_free;
    logic                  skip;
    logic [COUNT_BITS-1:0] n_new;
    logic                  n_dec_en;
    logic                  n_inc_en;

    // key count memory ports
    logic                  key_wr_en;
    logic [KEY_BITS-1:0]   key_wr_addr;
    logic [COUNT_BITS-1:0] key_wr_data;
    logic [COUNT_BITS-1:0] key_rd_data;

    // histogram memory ports
    logic                  hist_wr_en;
    logic [COUNT_BITS-1:0] hist_wr_addr;
    logic [HIST_BITS-1:0]  hist_wr_data;
    logic                  hist_rd_en;
    logic [COUNT_BITS-1:0] hist_rd_addr;
    logic [HIST_BITS-1:0]  hist_rd_data;

    assign i_req.ready = !r_clr_busy && (r_state == ST_IDLE || r_state == ST_INC);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // next count and bin updates from the stored count
    always_comb begin
        skip     = 1'b1;
        n_new    = key_rd_data;
        n_dec_en = 1'b0;
        n_inc_en = 1'b0;
        case (r_op)
            REQ_INSERT: begin
                skip     = (key_rd_data == COUNT_MAX);
                n_new    = key_rd_data + COUNT_BITS'(1);
                n_dec_en = (key_rd_data != '0);
                n_inc_en = 1'b1;
            end
            REQ_DELETE: begin
                skip     = (key_rd_data == '0);
                n_new    = key_rd_data - COUNT_BITS'(1);
                n_dec_en = 1'b1;
                n_inc_en = (key_rd_data != COUNT_BITS'(1));
            end
            default: begin
                skip = 1'b1;
            end
        endcase
    end

    always_comb begin
        key_wr_en    = 1'b0;
        key_wr_addr  = r_key;
        key_wr_data  = r_new;
        hist_wr_en   = 1'b0;
        hist_wr_addr = r_old;
        hist_wr_data = hist_rd_data - HIST_BITS'(1);
        hist_rd_en   = 1'b0;
        hist_rd_addr = key_rd_data;

        if (r_clr_busy) begin
            key_wr_en    = 1'b1;
            key_wr_addr  = r_clr_addr[KEY_BITS-1:0];
            key_wr_data  = '0;
            hist_wr_en   = 1'b1;
            hist_wr_addr = r_clr_addr[COUNT_BITS-1:0];
            hist_wr_data = '0;
        end else begin
            case (r_state)
                ST_CNT: begin
                    key_wr_en    = !skip;
                    key_wr_data  = n_new;
                    hist_rd_en   = !skip;
                    hist_rd_addr = key_rd_data;
                end
                ST_DEC: begin
                    hist_wr_en   = r_dec_en;
                    hist_wr_addr = r_old;
                    hist_wr_data = hist_rd_data - HIST_BITS'(1);
                    hist_rd_en   = 1'b1;
                    hist_rd_addr = r_new;
                end
                ST_INC: begin
                    hist_wr_en   = r_inc_en;
                    hist_wr_addr = r_new;
                    hist_wr_data = hist_rd_data + HIST_BITS'(1);
                end
                ST_QRD: begin
                    hist_rd_en   = 1'b1;
                    hist_rd_addr = r_want;
                end
                default: begin
                    hist_rd_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + CLR_BITS'(1);
                if (r_clr_addr == {CLR_BITS{1'b1}}) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (r_state == ST_QOUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CNT: begin
                    r_old    <= key_rd_data;
                    r_new    <= n_new;
                    r_dec_en <= n_dec_en;
                    r_inc_en <= n_inc_en;
                    r_state  <= skip ? ST_IDLE : ST_DEC;
                end
                ST_DEC: begin
                    r_state <= ST_INC;
                end
                ST_QRD: begin
                    r_state <= ST_QOUT;
                end
                ST_QOUT: begin
                    // hold the result until the output slot is free
                    if (out_free) begin
                        r_found <= (r_want != '0) && (hist_rd_data != '0);
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    // idle or last bin update: take the next request
                    if (accept) begin
                        case (i_req.req_type)
                            REQ_INSERT, REQ_DELETE: r_state <= ST_CNT;
                            REQ_QUERY:              r_state <= ST_QRD;
                            default:                r_state <= ST_IDLE;
                        endcase
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase

            if (accept) begin
                r_op   <= i_req.req_type;
                r_key  <= i_req.key;
                r_want <= i_req.asked_freq;
            end
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.found = r_found;

    fthc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_wr_en),
        .i_wr_addr (key_wr_addr),
        .i_wr_data (key_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (i_req.key),
        .o_rd_data (key_rd_data)
    );

    fthc_ram #(
        .WIDTH (HIST_BITS),
        .DEPTH (CNT_DEPTH)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hist_wr_en),
        .i_wr_addr (hist_wr_addr),
        .i_wr_data (hist_wr_data),
        .i_rd_en   (hist_rd_en),
        .i_rd_addr (hist_rd_addr),
        .o_rd_data (hist_rd_data)
    );

endmodule

/* test/fthc_query_checker.sv */
`timescale 1ns / 1ps
// Response checker for the frequency table core: mirrors per-key counts and the
// count histogram from accepted requests and compares every query response.
// Depends on fthc_pkg.
module fthc_query_checker
    import fthc_pkg::*;
#(
    parameter int KEY_BITS   = 10,
    parameter int COUNT_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [REQ_BITS-1:0]   i_req_type,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [COUNT_BITS-1:0] i_asked_freq,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  logic                  i_found,
    output int unsigned           o_fail_count,
    output int unsigned           o_pending
);

    localparam int KEY_DEPTH   = 1 << KEY_BITS;
    localparam int COUNT_DEPTH = 1 << COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    logic [COUNT_BITS-1:0] occurrences   [KEY_DEPTH];
    logic [KEY_BITS:0]     keys_at_count [COUNT_DEPTH];
    logic                  found_due     [$];
    logic                  found_want;
    int unsigned           mismatches = 0;

    // Apply one request to the mirrored tables; a query queues the answer it must get.
    task automatic apply_request(input logic [REQ_BITS-1:0] kind,
                                 input logic [KEY_BITS-1:0] key,
                                 input logic [COUNT_BITS-1:0] freq);
        logic [COUNT_BITS-1:0] cnt;
        cnt = occurrences[key];
        case (kind)
            REQ_INSERT: begin
                if (cnt != COUNT_TOP) begin
                    if (cnt != '0)
                        keys_at_count[cnt] = keys_at_count[cnt] - (KEY_BITS+1)'(1);
                    cnt = cnt + COUNT_BITS'(1);
                    occurrences[key] = cnt;
                    keys_at_count[cnt] = keys_at_count[cnt] + (KEY_BITS+1)'(1);
                end
            end
            REQ_DELETE: begin
                if (cnt != '0) begin
                    keys_at_count[cnt] = keys_at_count[cnt] - (KEY_BITS+1)'(1);
                    cnt = cnt - COUNT_BITS'(1);
                    occurrences[key] = cnt;
                    if (cnt != '0)
                        keys_at_count[cnt] = keys_at_count[cnt] + (KEY_BITS+1)'(1);
                end
            end
            REQ_QUERY: begin
                // keys at count zero are not tracked, so a query for zero never hits
                found_due = {found_due, (freq != '0 && keys_at_count[freq] != '0)};
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (occurrences[i]) occurrences[i] = '0;
            foreach (keys_at_count[i]) keys_at_count[i] = '0;
            found_due.delete();
        end else begin
            // responses first: a request taken at this edge cannot answer at it
            if (i_rsp_valid && i_rsp_ready) begin
                if (found_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: found expected none, actual %0b", $time, i_found);
                end else begin
                    found_want = found_due.pop_front();
                    if (i_found !== found_want) begin
                        mismatches++;
                        $display("%0t: found expected %0b, actual %0b",
                                 $time, found_want, i_found);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                apply_request(i_req_type, i_key, i_asked_freq);
        end
        o_fail_count <= mismatches;
        o_pending    <= found_due.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the frequency table core: clock, reset, request stimulus,
// response back-pressure and the verdict; checking lives in fthc_query_checker.
// Depends on fthc_pkg, fthc_if, the core and fthc_query_checker.
module tb_top;
    import fthc_pkg::*;

    localparam int KEY_BITS     = 10;
    localparam int COUNT_BITS   = 8;
    localparam int KEY_MAX      = (1 << KEY_BITS) - 1;
    localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
    localparam int HOT_KEYS     = 8;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [REQ_BITS-1:0]   REQ_UNUSED = '1;
    localparam logic [KEY_BITS-1:0]   KEY_TOP    = '1;
    localparam logic [COUNT_BITS-1:0] FREQ_TOP   = '1;

    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    int unsigned         fail_count;
    int unsigned         pending;
    int unsigned         cycle_count = 0;
    bit                  send_idling = 1'b0;
    bit                  take_idling = 1'b0;
    int                  holds_asked = 0;
    int                  holds_done  = 0;
    logic [KEY_BITS-1:0] hot_keys [HOT_KEYS];

    fthc_req_if #(.KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)) req_if ();
    fthc_rsp_if rsp_if ();

    frequency_table_with_count_histogram_core #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    fthc_query_checker #(
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req_type   (req_if.req_type),
        .i_key        (req_if.key),
        .i_asked_freq (req_if.asked_freq),
        .i_rsp_valid  (rsp_if.valid),
        .i_rsp_ready  (rsp_if.ready),
        .i_found      (rsp_if.found),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("frequency_table_with_count_histogram_core test failed");
        $finish;
    end

    // Response side: random stall bursts, plus one long hold-off when asked.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                rsp_if.ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end else if (take_idling && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic [KEY_BITS-1:0] rand_key();
        return KEY_BITS'($urandom_range(0, KEY_MAX));
    endfunction

    function automatic logic [COUNT_BITS-1:0] rand_freq();
        return COUNT_BITS'($urandom_range(0, COUNT_MAX));
    endfunction

    // Offer one request and hold it until the edge that takes it.
    task automatic send(input logic [REQ_BITS-1:0] kind, input logic [KEY_BITS-1:0] key,
                        input logic [COUNT_BITS-1:0] freq);
        if (send_idling && $urandom_range(0, 7) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.key        <= key;
        req_if.asked_freq <= freq;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // Drop valid and wait for every outstanding query to be answered.
    task automatic drain_queries();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic shuffle_hot_keys();
        int r;
        foreach (hot_keys[i]) begin
            r = $urandom_range(0, 9);
            hot_keys[i] = (r == 0) ? '0 : (r == 1) ? KEY_TOP : rand_key();
        end
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key(input int pool);
        if ($urandom_range(0, 4) != 0)
            return hot_keys[$urandom_range(0, pool - 1)];
        return rand_key();
    endfunction

    // Mostly small counts, where hot keys actually sit; sometimes anything.
    function automatic logic [COUNT_BITS-1:0] pick_freq();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return COUNT_BITS'($urandom_range(0, 14));
        if (r == 7)
            return FREQ_TOP;
        return rand_freq();
    endfunction

    function automatic logic [COUNT_BITS-1:0] freq_near(input int level);
        int want;
        want = level - 2 + int'($urandom_range(0, 3));
        if (want < 0)
            want = 0;
        if (want > COUNT_MAX)
            want = COUNT_MAX;
        return COUNT_BITS'(want);
    endfunction

    task automatic send_mixed(input int count, input int pool);
        int sent;
        int r;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send(REQ_INSERT, pick_key(pool), rand_freq());
            end else if (r < 70) begin
                send(REQ_DELETE, pick_key(pool), rand_freq());
            end else if (r < 97) begin
                send(REQ_QUERY, rand_key(), pick_freq());
            end else begin
                send(REQ_UNUSED, rand_key(), rand_freq());
                sent--;
            end
            sent++;
        end
    endtask

    // Drive one key past the top count, probing the bins around it, then back off.
    task automatic saturate_key();
        logic [KEY_BITS-1:0] key;
        int                  level;
        key   = rand_key();
        level = 0;
        while (level < COUNT_MAX + 4) begin
            send(REQ_INSERT, key, rand_freq());
            level++;
            if ($urandom_range(0, 7) == 0)
                send(REQ_QUERY, rand_key(), freq_near(level));
        end
        level = COUNT_MAX;
        send(REQ_QUERY, rand_key(), FREQ_TOP);
        send(REQ_QUERY, rand_key(), FREQ_TOP - COUNT_BITS'(1));
        repeat (12) begin
            send(REQ_DELETE, key, rand_freq());
            level--;
            send(REQ_QUERY, rand_key(), freq_near(level + 1));
        end
    endtask

    initial begin
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_INSERT;
        req_if.key        = '0;
        req_if.asked_freq = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unused code, zero and extreme keys, bins moving up and down
        send(REQ_QUERY, '0, 8'd0);
        send(REQ_QUERY, '0, 8'd1);
        send(REQ_QUERY, KEY_TOP, FREQ_TOP);
        send(REQ_DELETE, 10'd5, 8'd0);
        send(REQ_UNUSED, 10'd5, 8'd1);
        send(REQ_INSERT, '0, FREQ_TOP);
        send(REQ_INSERT, KEY_TOP, 8'd0);
        send(REQ_QUERY, KEY_TOP, 8'd1);
        send(REQ_QUERY, '0, 8'd0);
        send(REQ_INSERT, KEY_TOP, 8'h55);
        send(REQ_QUERY, 10'h2AA, 8'd2);
        send(REQ_QUERY, 10'h155, 8'd1);
        send(REQ_DELETE, '0, 8'hAA);
        send(REQ_QUERY, '0, 8'd1);
        send(REQ_DELETE, '0, 8'd0);
        send(REQ_DELETE, KEY_TOP, 8'd0);
        send(REQ_QUERY, '0, 8'd2);
        send(REQ_QUERY, '0, 8'd1);
        send(REQ_INSERT, 10'h2AA, 8'hFF);
        send(REQ_INSERT, 10'h155, 8'h00);
        send(REQ_QUERY, KEY_TOP, 8'hAA);
        send(REQ_QUERY, '0, 8'h55);
        send(REQ_QUERY, KEY_TOP, 8'd1);

        send_idling = 1'b1;
        take_idling = 1'b1;
        shuffle_hot_keys();
        send_mixed(200, 6);
        saturate_key();

        // pause the requests until every query has been answered
        drain_queries();

        // hold responses off while queries keep coming, so the core backs up
        holds_asked++;
        repeat (40) send(REQ_QUERY, rand_key(), pick_freq());

        shuffle_hot_keys();
        send_mixed(200, 3);
        shuffle_hot_keys();
        send_mixed(100, HOT_KEYS);

        send_idling = 1'b0;
        take_idling = 1'b0;
        send_mixed(100, 4);

        drain_queries();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("frequency_table_with_count_histogram_core test passed");
        else
            $display("frequency_table_with_count_histogram_core test failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/fthc_pkg.sv
hdl/fthc_if.sv
hdl/fthc_ram.sv
hdl/frequency_table_with_count_histogram_core.sv
test/fthc_query_checker.sv
test/tb_top.sv
